// ===== rtl/mhr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhr_pkg
// Types and constants for the measurement history ring.
// ----------------------------------------------------------------------------
package mhr_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int TICK_W  = 32;
    localparam int SESS_W  = 16;
    localparam int CODE_W  = 8;
    localparam int MEAS_W  = 32;
    localparam int RIDX_W  = 6;
    localparam int HELD_W  = 7;
    localparam int TOTAL_W = 32;
    localparam int WPOS_W  = 6;

    localparam int IN_DATA_W  = 128;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 168;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [IN_USER_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_STATUS = 2'd3
    } req_t;

    // stored record, tick in the lowest bits
    typedef struct packed {
        logic [CODE_W-1:0] cond;
        logic [CODE_W-1:0] tlevel;
        logic [MEAS_W-1:0] meas;
        logic [CODE_W-1:0] run;
        logic [CODE_W-1:0] dstate;
        logic [CODE_W-1:0] err;
        logic [SESS_W-1:0] sess;
        logic [TICK_W-1:0] tick;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage : mhr_pkg
`default_nettype wire

// ===== rtl/measurement_history_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// measurement_history_ring
// Overwriting history store of sensor records with logical-index read-back.
// ----------------------------------------------------------------------------
// Path: a request beat passes through the synchronous record memory read and
//   stage-one registers, then the output register.
// Throughput: one request per cycle while the output side is not stalled;
//   each request touches the record memory at most once.
// Reset: clears write position, count, lifetime total and pipeline valids;
//   record memory contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module measurement_history_ring #(
    parameter int DEPTH = mhr_pkg::DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // tick_ms[31:0], session[47:32], sensor_error[55:48], cached_state[63:56],
    // error_run[71:64], measured[103:72], temp_level[111:104],
    // condition_code[119:112], read_index[125:120], zero pad
    input  wire logic [mhr_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  wire logic [mhr_pkg::IN_USER_W-1:0]  s_tuser,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // ok[0], out_tick_ms[32:1], out_session[48:33], out_error[56:49],
    // out_data_state[64:57], out_error_run[72:65], out_measured[104:73],
    // out_temp_level[112:105], out_condition[120:113], held_count[127:121],
    // lifetime_total[159:128], write_pos[165:160], zero pad
    output      logic [mhr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mhr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
    localparam int SUM_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);
    localparam int PAD_W = OUT_DATA_W - 1 - REC_W - HELD_W - TOTAL_W - WPOS_W;

    // request fields
    req_t              req;
    rec_t              in_rec;
    logic [RIDX_W-1:0] read_index;

    // state
    logic [PTR_W-1:0]   wpos_reg,  wpos_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // record memory
    rec_t             rec_mem [DEPTH];
    rec_t             rd_data_reg;
    rec_t             wr_rec;
    logic             wr_en;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;

    // stage one: memory access
    logic               s1_valid_reg;
    logic               s1_ok_reg;
    logic               s1_hit_reg;
    logic [CNT_W-1:0]   s1_cnt_reg;
    logic [TOTAL_W-1:0] s1_total_reg;
    logic [PTR_W-1:0]   s1_wpos_reg;
    logic               s1_adv;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    rec_t                  out_rec;

    logic             acc;
    logic             ok_next;
    logic             hit;
    logic [CMP_W-1:0] idx_cmp;
    logic [CMP_W-1:0] cnt_cmp;
    logic [SUM_W-1:0] oldest_sum;
    logic [PTR_W-1:0] oldest;
    logic [SUM_W-1:0] phys_sum;

    assign req        = req_t'(s_tuser);
    assign in_rec     = rec_t'(s_tdata[REC_W-1:0]);
    assign read_index = s_tdata[REC_W +: RIDX_W];

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign acc      = s_tvalid && s_tready;

    // logical to physical slot
    assign idx_cmp    = CMP_W'(read_index);
    assign cnt_cmp    = CMP_W'(cnt_reg);
    assign hit        = idx_cmp < cnt_cmp;
    assign oldest_sum = SUM_W'(wpos_reg) + SUM_DEPTH - SUM_W'(cnt_reg);
    assign oldest     = (oldest_sum >= SUM_DEPTH) ? PTR_W'(oldest_sum - SUM_DEPTH)
                                                  : PTR_W'(oldest_sum);
    assign phys_sum   = SUM_W'(oldest) + SUM_W'(read_index[RIDX_W-1:0]);
    assign rd_addr    = (phys_sum >= SUM_DEPTH) ? PTR_W'(phys_sum - SUM_DEPTH)
                                                : PTR_W'(phys_sum);

    always_comb
    begin
        wr_rec = in_rec;
        if (in_rec.err != '0)
        begin
            wr_rec.meas   = '0;
            wr_rec.tlevel = '0;
            wr_rec.cond   = '0;
        end
    end

    always_comb
    begin
        wpos_next  = wpos_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        ok_next    = 1'b1;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        unique case (req)
            REQ_APPEND:
            begin
                if (in_rec.sess != '0)
                begin
                    wr_en     = acc;
                    wpos_next = (wpos_reg == PTR_LAST) ? '0 : wpos_reg + 1'b1;
                    if (cnt_reg < CNT_FULL)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (total_reg != TOTAL_MAX)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            REQ_READ:
            begin
                ok_next = hit;
                rd_en   = acc && hit;
            end
            REQ_CLEAR:
            begin
                wpos_next = '0;
                cnt_next  = '0;
            end
            REQ_STATUS:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[wpos_reg] <= wr_rec;
        end
        if (rd_en)
        begin
            rd_data_reg <= rec_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg     <= '0;
            cnt_reg      <= '0;
            total_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                wpos_reg  <= wpos_next;
                cnt_reg   <= cnt_next;
                total_reg <= total_next;
            end
            if (acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ok_reg    <= ok_next;
            s1_hit_reg   <= (req == REQ_READ) && hit;
            s1_cnt_reg   <= cnt_next;
            s1_total_reg <= total_next;
            s1_wpos_reg  <= wpos_next;
        end
    end

    assign out_rec = s1_hit_reg ? rd_data_reg : '0;

    assign out_data_next = {
        {PAD_W{1'b0}},
        WPOS_W'(s1_wpos_reg),
        s1_total_reg,
        HELD_W'(s1_cnt_reg),
        out_rec.cond,
        out_rec.tlevel,
        out_rec.meas,
        out_rec.run,
        out_rec.dstate,
        out_rec.err,
        out_rec.sess,
        out_rec.tick,
        s1_ok_reg
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("record count above depth");

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> total_reg >= $past(total_reg))
        else $error("lifetime total went down");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        acc && req == REQ_CLEAR |=> cnt_reg == '0 && wpos_reg == '0)
        else $error("clear left counters set");

    a_hold_mem_data: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_hit_reg && !s1_adv |=> $stable(rd_data_reg))
        else $error("read data lost while stage stalled");
`endif

endmodule : measurement_history_ring
`default_nettype wire

// ===== tb/sv/measurement_history_ring_test.sv =====
// ----------------------------------------------------------------------------
// measurement_history_ring_test
// Self-checking bench for the measurement history ring. A queue-fed driver
// sends request beats and predicts each reply as its beat is accepted. A
// monitor compares every reply beat, field by field, with the oldest
// prediction. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module measurement_history_ring_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mhr_pkg::*;

    localparam int DEPTH            = DEPTH_DEF;
    localparam int RANDOM_PER_PHASE = 534;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 8;

    // lowest bits first: tick_ms, session, sensor_error, cached_state,
    // error_run, measured, temp_level, condition_code, read_index, pad
    typedef struct packed {
        logic [1:0]        pad;
        logic [RIDX_W-1:0] read_index;
        logic [CODE_W-1:0] condition_code;
        logic [CODE_W-1:0] temp_level;
        logic [MEAS_W-1:0] measured;
        logic [CODE_W-1:0] error_run;
        logic [CODE_W-1:0] cached_state;
        logic [CODE_W-1:0] sensor_error;
        logic [SESS_W-1:0] session;
        logic [TICK_W-1:0] tick_ms;
    } request_t;

    typedef struct packed {
        logic [1:0]         pad;
        logic [WPOS_W-1:0]  write_pos;
        logic [TOTAL_W-1:0] lifetime_total;
        logic [HELD_W-1:0]  held_count;
        logic [CODE_W-1:0]  condition;
        logic [CODE_W-1:0]  temp_level;
        logic [MEAS_W-1:0]  measured;
        logic [CODE_W-1:0]  error_run;
        logic [CODE_W-1:0]  cached_state;
        logic [CODE_W-1:0]  error;
        logic [SESS_W-1:0]  session;
        logic [TICK_W-1:0]  tick_ms;
        logic               ok;
    } reply_t;

    typedef struct {
        req_t     kind;
        request_t body;
    } request_beat_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    request_beat_t pending_requests[$];
    reply_t        expected_replies[$];
    request_beat_t next_beat;

    int unsigned requests_queued    = 0;
    int unsigned replies_seen       = 0;
    int unsigned mismatches         = 0;
    int unsigned quiet_cycles       = 0;
    int unsigned sender_idle_pct    = 13;
    int unsigned receiver_stall_pct = 75;

    // predicted ring state
    rec_t               history[DEPTH];
    int                 slot_next = 0;
    int                 held      = 0;
    logic [TOTAL_W-1:0] total     = '0;

    measurement_history_ring #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic reply_t predict_reply(req_t kind, request_t rq);
        reply_t r;
        rec_t   rec;
        int     oldest;
        r = '0;
        case (kind)
            REQ_APPEND:
            begin
                if (rq.session != '0)
                begin
                    rec        = '0;
                    rec.tick   = rq.tick_ms;
                    rec.sess   = rq.session;
                    rec.err    = rq.sensor_error;
                    rec.dstate = rq.cached_state;
                    rec.run    = rq.error_run;
                    if (rq.sensor_error == '0)
                    begin
                        rec.meas   = rq.measured;
                        rec.tlevel = rq.temp_level;
                        rec.cond   = rq.condition_code;
                    end
                    history[slot_next] = rec;
                    slot_next = (slot_next + 1) % DEPTH;
                    if (held < DEPTH)
                        held++;
                    if (total != TOTAL_MAX)
                        total++;
                    r.ok = 1'b1;
                end
            end
            REQ_READ:
            begin
                if (int'(rq.read_index) < held)
                begin
                    oldest           = (slot_next + DEPTH - held) % DEPTH;
                    rec              = history[(oldest + int'(rq.read_index)) % DEPTH];
                    r.ok             = 1'b1;
                    r.tick_ms        = rec.tick;
                    r.session        = rec.sess;
                    r.error          = rec.err;
                    r.cached_state   = rec.dstate;
                    r.error_run      = rec.run;
                    r.measured       = rec.meas;
                    r.temp_level     = rec.tlevel;
                    r.condition      = rec.cond;
                end
            end
            REQ_CLEAR:
            begin
                slot_next = 0;
                held      = 0;
                r.ok      = 1'b1;
            end
            default:
                r.ok = 1'b1;
        endcase
        r.held_count     = HELD_W'(held);
        r.lifetime_total = total;
        r.write_pos      = WPOS_W'(slot_next);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void compare_reply(reply_t want, reply_t got);
        check_field("ok", want.ok, got.ok);
        check_field("out_tick_ms", want.tick_ms, got.tick_ms);
        check_field("out_session", want.session, got.session);
        check_field("out_error", want.error, got.error);
        check_field("out_data_state", want.cached_state, got.cached_state);
        check_field("out_error_run", want.error_run, got.error_run);
        check_field("out_measured", want.measured, got.measured);
        check_field("out_temp_level", want.temp_level, got.temp_level);
        check_field("out_condition", want.condition, got.condition);
        check_field("held_count", want.held_count, got.held_count);
        check_field("lifetime_total", want.lifetime_total, got.lifetime_total);
        check_field("write_pos", want.write_pos, got.write_pos);
    endfunction

    task automatic queue_request(req_t kind, request_t body);
        request_beat_t b;
        b.kind     = kind;
        b.body     = body;
        b.body.pad = '0;
        pending_requests.push_back(b);
        requests_queued++;
    endtask

    function automatic request_beat_t random_request();
        request_beat_t b;
        int            pick;
        b.body     = {$urandom, $urandom, $urandom, $urandom};
        b.body.pad = '0;
        pick       = $urandom_range(0, 999);
        if (pick < 520)
            b.kind = REQ_APPEND;
        else if (pick < 880)
            b.kind = REQ_READ;
        else if (pick < 996)
            b.kind = REQ_STATUS;
        else
            b.kind = REQ_CLEAR;
        if (b.kind == REQ_APPEND)
        begin
            if ($urandom_range(0, 15) == 0)
                b.body.session = '0;
            if ($urandom_range(0, 1) == 0)
                b.body.sensor_error = '0;
        end
        else if (b.kind == REQ_READ && $urandom_range(0, 3) == 0)
            b.body.read_index = RIDX_W'($urandom_range(0, 7));
        return b;
    endfunction

    // driver: predicts at acceptance, then offers the next pending beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_replies.push_back(predict_reply(req_t'(s_tuser), request_t'(s_tdata)));
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_beat = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_beat.kind;
                    s_tdata  <= next_beat.body;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            quiet_cycles  = 0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            if (m_tvalid && m_tready)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    $error("reply beat with no request outstanding");
                    mismatches++;
                end
                else
                    compare_reply(expected_replies.pop_front(), reply_t'(m_tdata));
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                replies_seen == requests_queued)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        request_t zeros;
        request_t ones;
        request_t b;
        zeros = '0;
        ones  = '1;

        queue_request(REQ_STATUS, zeros);
        queue_request(REQ_READ, zeros);
        queue_request(REQ_APPEND, zeros);
        b = ones;
        b.sensor_error = '0;
        queue_request(REQ_APPEND, b);
        b = zeros;
        b.session = 16'h0001;
        queue_request(REQ_APPEND, b);
        queue_request(REQ_APPEND, ones);
        b = zeros;
        b.session        = 16'h8000;
        b.sensor_error   = 8'h01;
        b.cached_state   = 8'h5A;
        b.error_run      = 8'h80;
        b.measured       = 32'hA5A5_5A5A;
        b.temp_level     = 8'h3C;
        b.condition_code = 8'hC3;
        queue_request(REQ_APPEND, b);
        for (int i = 0; i < 5; i++)
        begin
            b = zeros;
            b.read_index = RIDX_W'(i);
            queue_request(REQ_READ, b);
        end
        queue_request(REQ_READ, ones);
        queue_request(REQ_STATUS, ones);
        queue_request(REQ_CLEAR, ones);
        queue_request(REQ_READ, zeros);
        queue_request(REQ_STATUS, zeros);
        b = ones;
        b.sensor_error = 8'h80;
        queue_request(REQ_APPEND, b);
        queue_request(REQ_READ, zeros);
        queue_request(REQ_CLEAR, zeros);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            @(negedge clk);
            case (phase)
                0:
                begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 75;
                end
                1:
                begin
                    sender_idle_pct    = 75;
                    receiver_stall_pct = 13;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                pending_requests.push_back(random_request());
            requests_queued += RANDOM_PER_PHASE;
            while (replies_seen != requests_queued)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule : measurement_history_ring_test
